// ===== design/fhm_pkg.sv =====
`default_nettype none

package fhm_pkg;

    // request opcodes
    typedef enum logic [0:0] {
        OP_LOCK   = 1'b0,
        OP_UNLOCK = 1'b1
    } opcode_t;

    // result codes
    typedef enum logic [2:0] {
        OUT_GRANTED   = 3'd0,
        OUT_QUEUED    = 3'd1,
        OUT_FREED     = 3'd2,
        OUT_HANDOFF   = 3'd3,
        OUT_NOT_OWNER = 3'd4,
        OUT_FULL      = 3'd5
    } outcome_t;

    localparam int TID_W     = 6;
    localparam int WAITERS_W = 7;

    typedef logic [TID_W-1:0] tid_t;

    // control from the lock logic to the wait chain
    typedef struct packed {
        logic push;
        logic pop;
        tid_t tid;
    } queue_ctrl_t;

endpackage

`default_nettype wire

// ===== design/fhm_wait_cell.sv =====
`default_nettype none

module fhm_wait_cell (
    input  wire logic        clk,
    input  wire logic        load,
    input  wire logic        shift,
    input  wire fhm_pkg::tid_t push_tid,
    input  wire fhm_pkg::tid_t right_tid,
    output fhm_pkg::tid_t    tid
);
    import fhm_pkg::*;

    tid_t tid_reg;
    tid_t tid_next;

    // take the neighbor's waiter on a pop, the new waiter on a push here
    always_comb
    begin
        tid_next = tid_reg;
        if (shift)
        begin
            tid_next = right_tid;
        end
        else if (load)
        begin
            tid_next = push_tid;
        end
    end

    always_ff @(posedge clk)
    begin
        tid_reg <= tid_next;
    end

    assign tid = tid_reg;

endmodule

`default_nettype wire

// ===== design/fhm_wait_chain.sv =====
`default_nettype none

module fhm_wait_chain #(
    parameter int MAX_THREADS = 64,
    parameter int CNT_W       = $clog2(MAX_THREADS + 1)
) (
    input  wire logic               clk,
    input  wire fhm_pkg::queue_ctrl_t ctrl,
    input  wire logic [CNT_W-1:0]   count,
    output fhm_pkg::tid_t           head_tid
);
    import fhm_pkg::*;

    tid_t cell_tid [MAX_THREADS];
    tid_t right_tid [MAX_THREADS];

    // row of cells, oldest waiter in cell zero, shifts toward the head on pop
    for (genvar i = 0; i < MAX_THREADS; i++)
    begin : g_cell
        logic load;

        assign load = ctrl.push && (count == CNT_W'(i));

        if (i == MAX_THREADS - 1)
        begin : g_last
            assign right_tid[i] = '0;
        end
        else
        begin : g_mid
            assign right_tid[i] = cell_tid[i+1];
        end

        fhm_wait_cell u_cell (
            .clk       (clk),
            .load      (load),
            .shift     (ctrl.pop),
            .push_tid  (ctrl.tid),
            .right_tid (right_tid[i]),
            .tid       (cell_tid[i])
        );
    end

    assign head_tid = cell_tid[0];

endmodule

`default_nettype wire

// ===== design/fifo_handoff_mutex_unit.sv =====
// Hardware mutex with a first-in first-out wait queue.
// Request channel (req_valid/req_ready): opcode 0 locks, 1 unlocks, tagged
// with thread_id. Response channel (rsp_valid/rsp_ready): one transaction per
// request with outcome, woken_thread, is_locked, current_owner and waiters.
// The response is registered: an accepted request shows its response in the
// cycle after. Throughput is one request per cycle while responses are taken;
// the owner check and a push or pop of the wait chain happen together; the
// cell chain shifts every waiter one place toward the head on each handoff.
// The response sits in an output register; a new request is taken whenever
// that register is empty or is being drained in the same cycle, so a
// stalled receiver holds the response and blocks new requests until taken.
// Reset frees the mutex, clears the owner and empties the queue; the queue
// cells themselves need no clearing since only filled cells are read.
// A lock on a held mutex with MAX_THREADS waiters answers queue full.
`default_nettype none

module fifo_handoff_mutex_unit #(
    parameter int MAX_THREADS = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_ready,
    input  wire logic         opcode,
    input  wire logic [5:0]   thread_id,
    output logic              rsp_valid,
    input  wire logic         rsp_ready,
    output logic [2:0]        outcome,
    output logic [5:0]        woken_thread,
    output logic              is_locked,
    output logic [5:0]        current_owner,
    output logic [6:0]        waiters
);
    import fhm_pkg::*;

    localparam int CNT_W = $clog2(MAX_THREADS + 1);

    // mutex state
    logic             held_reg,  held_next;
    tid_t             owner_reg, owner_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // response register
    logic             rsp_valid_reg, rsp_valid_next;
    outcome_t         outcome_reg,   outcome_next;
    tid_t             woken_reg,     woken_next;
    logic             locked_reg,    locked_next;
    tid_t             cur_owner_reg, cur_owner_next;
    logic [CNT_W-1:0] waiters_reg,   waiters_next;

    logic             accept;
    queue_ctrl_t      qctrl;
    tid_t             head_tid;
    logic             full;
    logic [CNT_W+WAITERS_W-1:0] waiters_ext;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign full      = (count_reg == CNT_W'(MAX_THREADS));

    // lock and unlock decision
    always_comb
    begin
        held_next   = held_reg;
        owner_next  = owner_reg;
        count_next  = count_reg;
        qctrl.push  = 1'b0;
        qctrl.pop   = 1'b0;
        qctrl.tid   = thread_id;
        woken_next  = '0;
        outcome_next = outcome_reg;

        if (opcode_t'(opcode) == OP_LOCK)
        begin
            if (!held_reg)
            begin
                held_next    = 1'b1;
                owner_next   = thread_id;
                outcome_next = OUT_GRANTED;
            end
            else if (full)
            begin
                outcome_next = OUT_FULL;
            end
            else
            begin
                qctrl.push   = accept;
                count_next   = count_reg + CNT_W'(1);
                outcome_next = OUT_QUEUED;
            end
        end
        else
        begin
            if (!held_reg || owner_reg != thread_id)
            begin
                outcome_next = OUT_NOT_OWNER;
            end
            else if (count_reg != '0)
            begin
                qctrl.pop    = accept;
                count_next   = count_reg - CNT_W'(1);
                owner_next   = head_tid;
                woken_next   = head_tid;
                outcome_next = OUT_HANDOFF;
            end
            else
            begin
                held_next    = 1'b0;
                owner_next   = '0;
                outcome_next = OUT_FREED;
            end
        end

        locked_next    = held_next;
        cur_owner_next = held_next ? owner_next : '0;
        waiters_next   = count_next;
        rsp_valid_next = accept ? 1'b1 : (rsp_valid_reg && !rsp_ready);
    end

    // state and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 1'b0;
            owner_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                held_reg  <= held_next;
                owner_reg <= owner_next;
                count_reg <= count_next;
            end
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            outcome_reg   <= outcome_next;
            woken_reg     <= woken_next;
            locked_reg    <= locked_next;
            cur_owner_reg <= cur_owner_next;
            waiters_reg   <= waiters_next;
        end
    end

    // wait queue as a chain of cells
    fhm_wait_chain #(
        .MAX_THREADS (MAX_THREADS),
        .CNT_W       (CNT_W)
    ) u_chain (
        .clk      (clk),
        .ctrl     (qctrl),
        .count    (count_reg),
        .head_tid (head_tid)
    );

    assign waiters_ext   = {{WAITERS_W{1'b0}}, waiters_reg};
    assign rsp_valid     = rsp_valid_reg;
    assign outcome       = outcome_reg;
    assign woken_thread  = woken_reg;
    assign is_locked     = locked_reg;
    assign current_owner = cur_owner_reg;
    assign waiters       = waiters_ext[WAITERS_W-1:0];

    // a free mutex has no waiters
    a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !held_reg |-> count_reg == '0)
        else $error("free mutex with waiters");

    // waiter count never exceeds the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_THREADS))
        else $error("waiter count overflow");

    // a handoff leaves the woken thread as owner
    a_handoff_owner: assert property (@(posedge clk) disable iff (!rst_n)
        accept && qctrl.pop |=> held_reg && owner_reg == woken_reg && rsp_valid_reg)
        else $error("handoff did not pass ownership");

    // a freed response reports an unlocked, empty mutex
    a_freed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && outcome_reg == OUT_FREED |-> !locked_reg && waiters_reg == '0)
        else $error("freed response inconsistent");

endmodule

`default_nettype wire

// ===== tb/tb_fifo_handoff_mutex_unit.sv =====
module tb_fifo_handoff_mutex_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fhm_pkg::*;

    localparam int WQ_DEPTH    = 64;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200000;

    // expected response of one lock or unlock request
    typedef struct packed {
        outcome_t               outcome;
        tid_t                   woken;
        logic                   locked;
        tid_t                   owner;
        logic [WAITERS_W-1:0]   waiters;
    } mutex_rsp_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    logic                   opcode = 1'b0;
    logic [TID_W-1:0]       thread_id = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    logic [2:0]             outcome;
    logic [TID_W-1:0]       woken_thread;
    logic                   is_locked;
    logic [TID_W-1:0]       current_owner;
    logic [WAITERS_W-1:0]   waiters;

    // mirror of the mutex state, advanced at each accepted request
    logic                   lk_held = 1'b0;
    tid_t                   lk_owner = '0;
    tid_t                   waitq [WQ_DEPTH];
    int                     wq_head = 0;
    int                     wq_tail = 0;
    int                     wq_count = 0;

    mutex_rsp_t             lock_rsp_q [$];

    // idling controls and receiver hold-off
    int                     send_idle_pct = 0;
    int                     rsp_stall_pct = 0;
    logic                   hold_go = 1'b0;
    logic                   hold_seen = 1'b0;
    int                     hold_left = 0;

    int                     err_count = 0;
    int                     reqs_sent = 0;
    int                     rsps_checked = 0;
    int                     cycle_count = 0;
    int                     outcome_hits [6] = '{default: 0};

    fifo_handoff_mutex_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .opcode        (opcode),
        .thread_id     (thread_id),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .outcome       (outcome),
        .woken_thread  (woken_thread),
        .is_locked     (is_locked),
        .current_owner (current_owner),
        .waiters       (waiters)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // apply one request to the mirror and return the response it must give
    function automatic mutex_rsp_t predict_lock_rsp(input opcode_t op, input tid_t tid);
        mutex_rsp_t r;
        r = '0;
        if (op == OP_LOCK)
        begin
            if (!lk_held)
            begin
                lk_held  = 1'b1;
                lk_owner = tid;
                r.outcome = OUT_GRANTED;
            end
            else if (wq_count >= WQ_DEPTH)
            begin
                r.outcome = OUT_FULL;
            end
            else
            begin
                waitq[wq_tail] = tid;
                wq_tail  = (wq_tail + 1) % WQ_DEPTH;
                wq_count = wq_count + 1;
                r.outcome = OUT_QUEUED;
            end
        end
        else
        begin
            if (!lk_held || lk_owner != tid)
            begin
                r.outcome = OUT_NOT_OWNER;
            end
            else if (wq_count > 0)
            begin
                r.woken  = waitq[wq_head];
                wq_head  = (wq_head + 1) % WQ_DEPTH;
                wq_count = wq_count - 1;
                lk_owner = r.woken;
                r.outcome = OUT_HANDOFF;
            end
            else
            begin
                lk_held  = 1'b0;
                lk_owner = '0;
                r.outcome = OUT_FREED;
            end
        end
        r.locked  = lk_held;
        r.owner   = lk_held ? lk_owner : '0;
        r.waiters = WAITERS_W'(wq_count);
        return r;
    endfunction

    // offer one request, with random idle cycles first; returns at acceptance
    task automatic send_req(input opcode_t op, input tid_t tid);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            opcode    <= 1'($urandom);
            thread_id <= TID_W'($urandom);
            @(posedge clk);
        end
        req_valid <= 1'b1;
        opcode    <= op;
        thread_id <= tid;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        lock_rsp_q.push_back(predict_lock_rsp(op, tid));
        reqs_sent++;
    endtask

    task automatic check_field(input string what, input logic [6:0] want, input logic [6:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            err_count++;
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // response checker
    always @(posedge clk)
    begin
        mutex_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (lock_rsp_q.size() == 0)
            begin
                $display("%0t: response with no request outstanding, actual outcome %0d",
                         $time, outcome);
                err_count++;
            end
            else
            begin
                want = lock_rsp_q.pop_front();
                check_field("outcome", 7'(want.outcome), 7'(outcome));
                check_field("woken_thread", 7'(want.woken), 7'(woken_thread));
                check_field("is_locked", 7'(want.locked), 7'(is_locked));
                check_field("current_owner", 7'(want.owner), 7'(current_owner));
                check_field("waiters", want.waiters, waiters);
                outcome_hits[want.outcome]++;
                rsps_checked++;
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, lock_rsp_q.size());
        $display("end of test: mismatches");
        $finish;
    end

    // extremes of thread id, every outcome but queue full, re-lock by owner, double queueing
    task automatic test_directed();
        send_idle_pct = 0;
        rsp_stall_pct <= 0;
        send_req(OP_UNLOCK, 6'd0);
        send_req(OP_UNLOCK, 6'd63);
        send_req(OP_LOCK,   6'd0);
        send_req(OP_UNLOCK, 6'd63);
        send_req(OP_LOCK,   6'd0);
        send_req(OP_LOCK,   6'd63);
        send_req(OP_LOCK,   6'd63);
        send_req(OP_UNLOCK, 6'd0);
        send_req(OP_UNLOCK, 6'd0);
        send_req(OP_UNLOCK, 6'd0);
        send_req(OP_UNLOCK, 6'd63);
        send_req(OP_UNLOCK, 6'd63);
        send_req(OP_UNLOCK, 6'd63);
        send_req(OP_LOCK,   6'd63);
        send_req(OP_LOCK,   6'd21);
        send_req(OP_LOCK,   6'd42);
        send_req(OP_UNLOCK, 6'd21);
        send_req(OP_UNLOCK, 6'd63);
        send_req(OP_UNLOCK, 6'd21);
        send_req(OP_UNLOCK, 6'd42);
        send_req(OP_LOCK,   6'd42);
        send_req(OP_UNLOCK, 6'd42);
    endtask

    // fill the queue to the brim, get a reject, then drain with handoffs
    task automatic test_queue_full();
        send_idle_pct = 11;
        rsp_stall_pct <= 11;
        send_req(OP_LOCK, 6'd5);
        for (int i = 0; i < WQ_DEPTH; i++)
            send_req(OP_LOCK, tid_t'(WQ_DEPTH - 1 - i));
        send_req(OP_LOCK, 6'd0);
        send_req(OP_UNLOCK, 6'd1);
        send_req(OP_LOCK, 6'd63);
        for (int i = 0; i <= WQ_DEPTH; i++)
            send_req(OP_UNLOCK, lk_owner);
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        rsp_stall_pct <= 0;
        hold_go <= ~hold_go;
        for (int i = 0; i < 16; i++)
        begin
            if (i % 3 == 2)
                send_req(OP_UNLOCK, lk_owner);
            else
                send_req(OP_LOCK, tid_t'($urandom_range(63)));
        end
    endtask

    // mostly well-formed traffic: owner unlocks, locks from any thread, stray unlocks
    task automatic test_random(input int n, input int idle_pct, input int stall_pct,
                               input int unlock_pct);
        int r;
        send_idle_pct = idle_pct;
        rsp_stall_pct <= stall_pct;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (lk_held && r < unlock_pct)
                send_req(OP_UNLOCK, lk_owner);
            else if (r >= 90)
                send_req(OP_UNLOCK, tid_t'($urandom_range(63)));
            else
                send_req(OP_LOCK, tid_t'($urandom_range(63)));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_queue_full();
        test_backpressure();
        test_random(40, 0, 0, 50);
        test_random(50, 76, 0, 55);
        test_random(50, 0, 76, 45);
        test_random(60, 11, 11, 15);
        test_random(40, 0, 0, 85);

        req_valid <= 1'b0;
        while (lock_rsp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("sent %0d requests, checked %0d responses in %0d cycles",
                 reqs_sent, rsps_checked, cycle_count);
        $display("granted %0d queued %0d freed %0d handoff %0d not-owner %0d full %0d",
                 outcome_hits[0], outcome_hits[1], outcome_hits[2],
                 outcome_hits[3], outcome_hits[4], outcome_hits[5]);
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
design/fhm_pkg.sv
design/fhm_wait_cell.sv
design/fhm_wait_chain.sv
design/fifo_handoff_mutex_unit.sv
tb/tb_fifo_handoff_mutex_unit.sv
